### hdl/ryc_pkg.sv
// ryc_pkg: word types, codes and fixed-point constants of the rgb to yuv 4:2:0 converter
// no dependencies; every other file but ryc_queue takes its names from here by scope
package ryc_pkg;

   // one input word: a pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // one result word
   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] u_average;
      logic [7:0] v_average;
      logic       end_of_frame;
   } result_type;

   // where a pixel sits in the frame, worked out by the front end
   typedef struct packed {
      logic col_odd;
      logic row_odd;
      logic eof;
   } tag_type;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_LINES = 2'd1;
   localparam logic [CSR_DATA_W-1:0]  RESET_LINE_WIDTH  = 11'd320;
   localparam logic [CSR_DATA_W-1:0]  RESET_FRAME_LINES = 11'd240;

   // q15 coefficients, signs are applied in the sums
   localparam int PROD_W = 23;
   localparam int ACC_W  = 25;
   localparam logic [14:0] COEF_YR = 15'd9798;
   localparam logic [14:0] COEF_YG = 15'd19235;
   localparam logic [14:0] COEF_YB = 15'd3736;
   localparam logic [14:0] COEF_UR = 15'd4821;
   localparam logic [14:0] COEF_UG = 15'd9465;
   localparam logic [14:0] COEF_UB = 15'd14287;
   localparam logic [14:0] COEF_VR = 15'd20152;
   localparam logic [14:0] COEF_VG = 15'd16875;
   localparam logic [14:0] COEF_VB = 15'd3277;
   localparam logic [ACC_W-1:0] CHROMA_OFFSET = 25'd4194304;

   // floor to a byte: negative gives 0, above 255 gives 255
   function automatic logic [7:0] sat_byte(input logic [ACC_W-1:0] acc);
      logic [8:0] q;
      q = acc[ACC_W-2:15];
      if (acc[ACC_W-1]) begin
         return 8'd0;
      end else if (q[8]) begin
         return 8'd255;
      end else begin
         return q[7:0];
      end
   endfunction

endpackage

### hdl/ryc_queue.sv
// ryc_queue: small first-in first-out word queue with a fill level
// generic width; uses no package
module ryc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic                       empty,
   output logic [$clog2(DEPTH):0]     level
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH) + 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]    level_ff, level_in;
   logic             do_push, do_pop;

   assign full    = (level_ff == LW'(DEPTH));
   assign empty   = (level_ff == '0);
   assign level   = level_ff;
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### hdl/ryc_front.sv
// ryc_front: configuration registers and raster position counters
// tags each accepted pixel with its place in the frame; uses ryc_pkg
module ryc_front #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_LINES = 1024,
   parameter int SLOT_W    = 9
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic                              cmd_full,
   output logic                              cmd_push,
   output ryc_pkg::tag_type                  cmd_tag,
   output logic [SLOT_W-1:0]                 cmd_slot,
   input  logic                              valid,
   output logic                              ready,
   input  logic [ryc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ryc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW    = (MAX_LINES > 2) ? $clog2(MAX_LINES) : 1;
   localparam int CMP_W = 14;

   // even value, clamped to 2..maxv
   function automatic logic [ryc_pkg::CSR_DATA_W-1:0] eff_size(
      input logic [ryc_pkg::CSR_DATA_W-1:0] v,
      input int                             maxv
   );
      logic [ryc_pkg::CSR_DATA_W-1:0] e;
      e = {v[ryc_pkg::CSR_DATA_W-1:1], 1'b0};
      if (e < ryc_pkg::CSR_DATA_W'(2)) begin
         e = ryc_pkg::CSR_DATA_W'(2);
      end
      if (int'(e) > maxv) begin
         e = ryc_pkg::CSR_DATA_W'(maxv);
      end
      return e;
   endfunction

   logic [ryc_pkg::CSR_DATA_W-1:0] width_ff, width_in;
   logic [ryc_pkg::CSR_DATA_W-1:0] lines_ff, lines_in;
   logic [CW-1:0]                  col_ff, col_in;
   logic [RW-1:0]                  row_ff, row_in;
   logic                           csr_wr, restart;
   logic                           col_last, row_last;

   assign ready    = 1'b1;
   assign csr_wr   = valid && ready;
   assign cmd_push = push && !cmd_full;

   assign col_last = (CMP_W'(col_ff) + CMP_W'(1)) >= CMP_W'(width_ff);
   assign row_last = (CMP_W'(row_ff) + CMP_W'(1)) >= CMP_W'(lines_ff);

   assign cmd_tag.col_odd = col_ff[0];
   assign cmd_tag.row_odd = row_ff[0];
   assign cmd_tag.eof     = col_last && row_last;
   assign cmd_slot        = SLOT_W'(col_ff >> 1);

   always_comb begin
      width_in = width_ff;
      lines_in = lines_ff;
      restart  = 1'b0;
      if (csr_wr) begin
         unique case (csr_index)
            ryc_pkg::REG_LINE_WIDTH: begin
               width_in = eff_size(csr_data, MAX_WIDTH);
               restart  = 1'b1;
            end
            ryc_pkg::REG_FRAME_LINES: begin
               lines_in = eff_size(csr_data, MAX_LINES);
               restart  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (cmd_push) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= eff_size(ryc_pkg::RESET_LINE_WIDTH, MAX_WIDTH);
         lines_ff <= eff_size(ryc_pkg::RESET_FRAME_LINES, MAX_LINES);
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         width_ff <= width_in;
         lines_ff <= lines_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

endmodule

### hdl/ryc_back.sv
// ryc_back: colour matrix pipeline, pair sums and chroma line store
// three stages feeding the result queue; uses ryc_pkg
module ryc_back #(
   parameter int MAX_WIDTH = 1024,
   parameter int SLOT_W    = 9,
   parameter int RES_DEPTH = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_empty,
   input  ryc_pkg::pixel_type             cmd_pixel,
   input  ryc_pkg::tag_type               cmd_tag,
   input  logic [SLOT_W-1:0]              cmd_slot,
   output logic                           cmd_pop,
   input  logic [$clog2(RES_DEPTH):0]     res_level,
   output logic                           res_push,
   output ryc_pkg::result_type            res_word
);

   localparam int STORE_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
   localparam int PW = ryc_pkg::PROD_W;
   localparam int AW = ryc_pkg::ACC_W;

   // stage a: products
   logic                    va_ff;
   logic [PW-1:0]           p_yr_ff, p_yg_ff, p_yb_ff;
   logic [PW-1:0]           p_ur_ff, p_ug_ff, p_ub_ff;
   logic [PW-1:0]           p_vr_ff, p_vg_ff, p_vb_ff;
   ryc_pkg::tag_type        tag_a_ff;
   logic [SLOT_W-1:0]       slot_a_ff;

   // stage b: saturated y, u, v
   logic                    vb_ff;
   logic [7:0]              y_b_ff, u_b_ff, v_b_ff;
   ryc_pkg::tag_type        tag_b_ff;
   logic [SLOT_W-1:0]       slot_b_ff;
   logic [AW-1:0]           acc_y, acc_u, acc_v;

   // stage c: pair sums and line store
   logic                    vc_ff;
   logic [7:0]              y_c_ff, u_c_ff, v_c_ff;
   ryc_pkg::tag_type        tag_c_ff;
   logic [SLOT_W-1:0]       slot_c_ff;
   logic [17:0]             store_rd_ff;
   logic [17:0]             store_mem [STORE_DEPTH];
   logic [8:0]              pair_u_ff, pair_u_in;
   logic [8:0]              pair_v_ff, pair_v_in;
   logic [9:0]              blk_u, blk_v;
   logic                    store_wr, chroma_ok;
   logic                    room;

   // issue only when the result queue can take every word in flight
   assign room    = (int'(res_level) + int'(va_ff) + int'(vb_ff) + int'(vc_ff)) < RES_DEPTH;
   assign cmd_pop = !cmd_empty && room;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= cmd_pop;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         p_yr_ff   <= PW'(cmd_pixel.red)   * ryc_pkg::COEF_YR;
         p_yg_ff   <= PW'(cmd_pixel.green) * ryc_pkg::COEF_YG;
         p_yb_ff   <= PW'(cmd_pixel.blue)  * ryc_pkg::COEF_YB;
         p_ur_ff   <= PW'(cmd_pixel.red)   * ryc_pkg::COEF_UR;
         p_ug_ff   <= PW'(cmd_pixel.green) * ryc_pkg::COEF_UG;
         p_ub_ff   <= PW'(cmd_pixel.blue)  * ryc_pkg::COEF_UB;
         p_vr_ff   <= PW'(cmd_pixel.red)   * ryc_pkg::COEF_VR;
         p_vg_ff   <= PW'(cmd_pixel.green) * ryc_pkg::COEF_VG;
         p_vb_ff   <= PW'(cmd_pixel.blue)  * ryc_pkg::COEF_VB;
         tag_a_ff  <= cmd_tag;
         slot_a_ff <= cmd_slot;
      end
   end

   // two's complement wrap is exact: every true sum fits in ACC_W bits
   assign acc_y = AW'(p_yr_ff) + AW'(p_yg_ff) + AW'(p_yb_ff);
   assign acc_u = ryc_pkg::CHROMA_OFFSET - AW'(p_ur_ff) - AW'(p_ug_ff) + AW'(p_ub_ff);
   assign acc_v = ryc_pkg::CHROMA_OFFSET + AW'(p_vr_ff) - AW'(p_vg_ff) - AW'(p_vb_ff);

   always_ff @(posedge clock) begin
      if (va_ff) begin
         y_b_ff    <= ryc_pkg::sat_byte(acc_y);
         u_b_ff    <= ryc_pkg::sat_byte(acc_u);
         v_b_ff    <= ryc_pkg::sat_byte(acc_v);
         tag_b_ff  <= tag_a_ff;
         slot_b_ff <= slot_a_ff;
      end
   end

   // line store: read on entry to stage c, written as an even-row, odd-column word leaves it
   always_ff @(posedge clock) begin
      if (vb_ff) begin
         store_rd_ff <= store_mem[slot_b_ff];
      end
      if (store_wr) begin
         store_mem[slot_c_ff] <= {pair_v_in, pair_u_in};
      end
   end

   always_ff @(posedge clock) begin
      if (vb_ff) begin
         y_c_ff    <= y_b_ff;
         u_c_ff    <= u_b_ff;
         v_c_ff    <= v_b_ff;
         tag_c_ff  <= tag_b_ff;
         slot_c_ff <= slot_b_ff;
      end
      if (vc_ff) begin
         pair_u_ff <= pair_u_in;
         pair_v_ff <= pair_v_in;
      end
   end

   always_comb begin
      if (tag_c_ff.col_odd) begin
         pair_u_in = pair_u_ff + 9'(u_c_ff);
         pair_v_in = pair_v_ff + 9'(v_c_ff);
      end else begin
         pair_u_in = 9'(u_c_ff);
         pair_v_in = 9'(v_c_ff);
      end
   end

   assign store_wr  = vc_ff && tag_c_ff.col_odd && !tag_c_ff.row_odd;
   assign chroma_ok = tag_c_ff.col_odd && tag_c_ff.row_odd;
   assign blk_u     = 10'(store_rd_ff[8:0]) + 10'(pair_u_in);
   assign blk_v     = 10'(store_rd_ff[17:9]) + 10'(pair_v_in);

   assign res_push              = vc_ff;
   assign res_word.luma         = y_c_ff;
   assign res_word.chroma_valid = chroma_ok;
   assign res_word.u_average    = chroma_ok ? blk_u[9:2] : 8'd0;
   assign res_word.v_average    = chroma_ok ? blk_v[9:2] : 8'd0;
   assign res_word.end_of_frame = tag_c_ff.eof;

endmodule

### hdl/rgb_to_yuv420_converter.sv
// rgb_to_yuv420_converter: top level, front end, command queue, back end, result queue
// depends on ryc_pkg, ryc_queue, ryc_front and ryc_back
//
// Takes raster-order rgb pixels and gives one word per pixel: the 8-bit luma, and on the
// odd-row, odd-column pixel of each 2x2 block the block's averaged u and v (4:2:0), with a
// flag on the last pixel of the frame. Sustained rate is one pixel per clock while results
// are popped as they come; a full result queue holds back the command queue and the input.
// Each pixel's word passes the command queue and stages a, b, c before it can be popped.
// The pace is set by the chroma line store, which takes one read and one write per clock
// on separate ports. The line store holds MAX_WIDTH/2 pair sums and is never cleared: it
// is filled by each even row before the odd row reads it. Writing line_width or
// frame_lines restarts the frame at the top-left pixel; write only while the block is idle.
module rgb_to_yuv420_converter #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_LINES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  ryc_pkg::pixel_type                req_pixel,
   output logic                              empty,
   input  logic                              pop,
   output ryc_pkg::result_type               rsp_result,
   input  logic                              valid,
   output logic                              ready,
   input  logic [ryc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ryc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CW        = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int SLOT_W    = (CW > 1) ? CW - 1 : 1;
   localparam int CMD_DEPTH = 4;
   localparam int RES_DEPTH = 8;
   localparam int PX_W      = $bits(ryc_pkg::pixel_type);
   localparam int TAG_W     = $bits(ryc_pkg::tag_type);
   localparam int CMD_W     = SLOT_W + TAG_W + PX_W;
   localparam int RES_W     = $bits(ryc_pkg::result_type);

   logic                          cmd_push, cmd_full, cmd_pop, cmd_empty;
   ryc_pkg::tag_type              front_tag;
   logic [SLOT_W-1:0]             front_slot;
   logic [CMD_W-1:0]              cmd_wdata, cmd_rdata;
   logic [$clog2(CMD_DEPTH):0]    cmd_level;
   ryc_pkg::pixel_type            back_pixel;
   ryc_pkg::tag_type              back_tag;
   logic [SLOT_W-1:0]             back_slot;
   logic                          res_push;
   ryc_pkg::result_type           res_word;
   logic [RES_W-1:0]              res_rdata;
   logic [$clog2(RES_DEPTH):0]    res_level;
   logic                          res_full;

   assign full       = cmd_full;
   assign cmd_wdata  = {front_slot, front_tag, req_pixel};
   assign back_pixel = cmd_rdata[PX_W-1:0];
   assign back_tag   = cmd_rdata[PX_W +: TAG_W];
   assign back_slot  = cmd_rdata[PX_W + TAG_W +: SLOT_W];
   assign rsp_result = res_rdata;

   ryc_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_LINES (MAX_LINES),
      .SLOT_W    (SLOT_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_tag   (front_tag),
      .cmd_slot  (front_slot),
      .valid     (valid),
      .ready     (ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   ryc_queue #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty),
      .level (cmd_level)
   );

   ryc_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .SLOT_W    (SLOT_W),
      .RES_DEPTH (RES_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pixel (back_pixel),
      .cmd_tag   (back_tag),
      .cmd_slot  (back_slot),
      .cmd_pop   (cmd_pop),
      .res_level (res_level),
      .res_push  (res_push),
      .res_word  (res_word)
   );

   // res_full never rises with a word in flight: the back end issues against the level
   ryc_queue #(
      .WIDTH (RES_W),
      .DEPTH (RES_DEPTH)
   ) u_res_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push && !res_full && (cmd_level <= ($clog2(CMD_DEPTH)+1)'(CMD_DEPTH))),
      .wdata (res_word),
      .full  (res_full),
      .pop   (pop),
      .rdata (res_rdata),
      .empty (empty),
      .level (res_level)
   );

endmodule
